// File: rtl/ur_pkg.sv
// ----------------------------------------------------------------------------
// ur_pkg
// Shared types, register indexes and constants for the ultrasonic ranger.
// ----------------------------------------------------------------------------
package ur_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_SCAN_TICKS        = 3'd0;
  localparam logic [2:0] CFG_SCANS_PER_MEASURE = 3'd1;
  localparam logic [2:0] CFG_BURST_PULSES      = 3'd2;
  localparam logic [2:0] CFG_HALF_PERIOD_TICKS = 3'd3;
  localparam logic [2:0] CFG_DISTANCE_SCALE    = 3'd4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned DIST_W      = 14;

  // distance reported when no echo arrives, and display clamp
  localparam logic [DIST_W-1:0] NO_ECHO_CM = 14'd9999;
  localparam logic [9:0]        SHOW_MAX   = 10'd999;
  localparam logic [7:0]        BLANK_SEG  = 8'hff;

  // ranger phases
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_ECHO = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] scan_ticks;
    logic [15:0] scans_per_measure;
    logic [7:0]  burst_pulses;
    logic [7:0]  half_period_ticks;
    logic [15:0] distance_scale;
  } cfg_t;

  // one decimal digit of the shown distance
  typedef logic [3:0] bcd_t;

  // common-anode, active-low segment patterns
  function automatic logic [7:0] seg_of(input bcd_t d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hf8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = BLANK_SEG;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/ur_config.sv
// ----------------------------------------------------------------------------
// ur_config
// Configuration register file; also exposes the value after this cycle's write.
// ----------------------------------------------------------------------------
module ur_config (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ur_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ur_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ur_pkg::cfg_t                      cfg,
  output ur_pkg::cfg_t                      cfg_next
);

  // write decode
  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      unique case (cfg_index)
        ur_pkg::CFG_SCAN_TICKS:        cfg_next.scan_ticks        = cfg_data;
        ur_pkg::CFG_SCANS_PER_MEASURE: cfg_next.scans_per_measure = cfg_data;
        ur_pkg::CFG_BURST_PULSES:      cfg_next.burst_pulses      = cfg_data[7:0];
        ur_pkg::CFG_HALF_PERIOD_TICKS: cfg_next.half_period_ticks = cfg_data[7:0];
        ur_pkg::CFG_DISTANCE_SCALE:    cfg_next.distance_scale    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_ticks        <= 16'd2000;
      cfg.scans_per_measure <= 16'd200;
      cfg.burst_pulses      <= 8'd9;
      cfg.half_period_ticks <= 8'd12;
      cfg.distance_scale    <= 16'd1114;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// File: rtl/ur_ranger.sv
// ----------------------------------------------------------------------------
// ur_ranger
// Burst transmitter, echo timer and distance store with decimal split.
// ----------------------------------------------------------------------------
module ur_ranger #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          echo_level,
  input  logic                          trigger_pending,
  input  ur_pkg::cfg_t                  cfg,
  input  ur_pkg::cfg_t                  cfg_next,
  output logic                          trigger_take,
  output logic                          tx_level,
  output logic                          distance_updated,
  output logic [ur_pkg::DIST_W-1:0]     distance_next,
  output ur_pkg::bcd_t [2:0]            digits_next
);

  localparam int unsigned PW = TIMER_BITS + 16;
  localparam int unsigned DW = (TIMER_BITS > ur_pkg::DIST_W) ? TIMER_BITS : ur_pkg::DIST_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  ur_pkg::phase_t             phase, phase_next;
  logic [7:0]                 pulse_count, pulse_count_next;
  logic [7:0]                 half_count, half_count_next;
  logic [TIMER_BITS-1:0]      echo_timer, echo_timer_next;
  logic [ur_pkg::DIST_W-1:0]  distance_value;
  ur_pkg::bcd_t [2:0]         shown_digits;
  logic [PW-1:0]              prod;
  logic [7:0]                 half_inc, pulse_inc;
  logic                       half_done;
  logic                       store;
  logic [ur_pkg::DIST_W-1:0]  store_value;
  logic [DW-1:0]              scaled;
  logic [ur_pkg::DIST_W-1:0]  scaled_sat;

  // split a value of at most 999 into hundreds, tens, units
  function automatic ur_pkg::bcd_t [2:0] to_digits(input logic [9:0] s);
    logic [15:0]        h_mul;
    logic [3:0]         h;
    logic [9:0]         r;
    logic [14:0]        t_mul;
    logic [3:0]         t;
    logic [6:0]         u;
    ur_pkg::bcd_t [2:0] d;
    h_mul = 16'(s) * 16'd41;
    h     = h_mul[15:12];
    r     = s - 10'(h) * 10'd100;
    t_mul = 15'(r[6:0]) * 15'd205;
    t     = t_mul[14:11];
    u     = r[6:0] - 7'(t) * 7'd10;
    d[0]  = h;
    d[1]  = t;
    d[2]  = u[3:0];
    return d;
  endfunction

  // product of the echo timer and scale, registered from their next-state values
  always_ff @(posedge clk) begin
    if (rst) begin
      prod <= '0;
    end else begin
      prod <= PW'(echo_timer_next) * PW'(cfg_next.distance_scale);
    end
  end

  // scaled distance with clamp to the no-echo value
  always_comb begin
    scaled     = DW'(prod[PW-1:16]);
    scaled_sat = (scaled > DW'(ur_pkg::NO_ECHO_CM)) ? ur_pkg::NO_ECHO_CM
                                                     : scaled[ur_pkg::DIST_W-1:0];
  end

  // phase sequencing
  always_comb begin
    phase_next       = phase;
    pulse_count_next = pulse_count;
    half_count_next  = half_count;
    echo_timer_next  = echo_timer;
    trigger_take     = 1'b0;
    tx_level         = 1'b0;
    store            = 1'b0;
    store_value      = scaled_sat;
    half_inc         = half_count + 8'd1;
    pulse_inc        = pulse_count + 8'd1;
    half_done        = (half_inc == 8'd0) || (half_inc >= cfg.half_period_ticks);
    unique case (phase)
      ur_pkg::PH_IDLE: begin
        if (trigger_pending) begin
          trigger_take     = 1'b1;
          phase_next       = ur_pkg::PH_HIGH;
          pulse_count_next = 8'd0;
          half_count_next  = 8'd0;
        end
      end
      ur_pkg::PH_HIGH: begin
        tx_level        = 1'b1;
        half_count_next = half_inc;
        if (half_done) begin
          half_count_next = 8'd0;
          phase_next      = ur_pkg::PH_LOW;
        end
      end
      ur_pkg::PH_LOW: begin
        half_count_next = half_inc;
        if (half_done) begin
          half_count_next  = 8'd0;
          pulse_count_next = pulse_inc;
          if ((pulse_inc == 8'd0) || (pulse_inc >= cfg.burst_pulses)) begin
            pulse_count_next = 8'd0;
            echo_timer_next  = '0;
            phase_next       = ur_pkg::PH_ECHO;
          end else begin
            phase_next = ur_pkg::PH_HIGH;
          end
        end
      end
      ur_pkg::PH_ECHO: begin
        if (!echo_level) begin
          store      = 1'b1;
          phase_next = ur_pkg::PH_IDLE;
        end else if (echo_timer == TMAX) begin
          echo_timer_next = '0;
          store           = 1'b1;
          store_value     = ur_pkg::NO_ECHO_CM;
          phase_next      = ur_pkg::PH_IDLE;
        end else begin
          echo_timer_next = echo_timer + TIMER_BITS'(1);
        end
      end
      default: ;
    endcase
    // hold everything when no item is taken
    if (!advance) begin
      phase_next       = phase;
      pulse_count_next = pulse_count;
      half_count_next  = half_count;
      echo_timer_next  = echo_timer;
      trigger_take     = 1'b0;
      store            = 1'b0;
    end
  end

  // stored distance and its display digits
  always_comb begin
    distance_updated = store;
    distance_next    = store ? store_value : distance_value;
    if (store) begin
      digits_next = to_digits((store_value > 14'(ur_pkg::SHOW_MAX)) ? ur_pkg::SHOW_MAX
                                                                     : store_value[9:0]);
    end else begin
      digits_next = shown_digits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ur_pkg::PH_IDLE;
      pulse_count    <= 8'd0;
      half_count     <= 8'd0;
      echo_timer     <= '0;
      distance_value <= '0;
      shown_digits   <= '0;
    end else begin
      phase          <= phase_next;
      pulse_count    <= pulse_count_next;
      half_count     <= half_count_next;
      echo_timer     <= echo_timer_next;
      distance_value <= distance_next;
      shown_digits   <= digits_next;
    end
  end

endmodule

// File: rtl/ur_display.sv
// ----------------------------------------------------------------------------
// ur_display
// Digit scan timer, measurement trigger and segment select.
// ----------------------------------------------------------------------------
module ur_display #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                trigger_take,
  input  ur_pkg::cfg_t        cfg,
  input  ur_pkg::bcd_t [2:0]  digits_next,
  output logic                trigger_pending,
  output logic [7:0]          digit_enable,
  output logic [7:0]          segment_pattern
);

  localparam logic [2:0] FIRST_SHOWN = 3'(DIGIT_COUNT - 3);
  localparam logic [3:0] LAST_POS    = 4'(DIGIT_COUNT);

  logic [15:0] tick_count, tick_count_next;
  logic [15:0] scan_count, scan_count_next;
  logic [2:0]  digit_position, digit_position_next;
  logic        trigger_pending_next;
  logic [15:0] tick_inc, scan_inc;
  logic [3:0]  pos_inc;
  logic [2:0]  slot;

  // scan timing
  always_comb begin
    tick_inc             = tick_count + 16'd1;
    scan_inc             = scan_count + 16'd1;
    pos_inc              = {1'b0, digit_position} + 4'd1;
    tick_count_next      = tick_count;
    scan_count_next      = scan_count;
    digit_position_next  = digit_position;
    trigger_pending_next = trigger_pending & ~trigger_take;
    if (advance) begin
      tick_count_next = tick_inc;
      if ((tick_inc == 16'd0) || (tick_inc >= cfg.scan_ticks)) begin
        tick_count_next     = 16'd0;
        digit_position_next = (pos_inc >= LAST_POS) ? 3'd0 : pos_inc[2:0];
        scan_count_next     = scan_inc;
        if ((scan_inc == 16'd0) || (scan_inc >= cfg.scans_per_measure)) begin
          scan_count_next      = 16'd0;
          trigger_pending_next = 1'b1;
        end
      end
    end
  end

  // digit select and segments for the position after this item
  always_comb begin
    slot         = digit_position_next - FIRST_SHOWN;
    digit_enable = 8'd1 << digit_position_next;
    if (digit_position_next >= FIRST_SHOWN) begin
      segment_pattern = ur_pkg::seg_of(digits_next[slot[1:0]]);
    end else begin
      segment_pattern = ur_pkg::BLANK_SEG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= 16'd0;
      scan_count      <= 16'd0;
      digit_position  <= 3'd0;
      trigger_pending <= 1'b0;
    end else begin
      tick_count      <= tick_count_next;
      scan_count      <= scan_count_next;
      digit_position  <= digit_position_next;
      trigger_pending <= trigger_pending_next;
    end
  end

endmodule

// File: rtl/ultrasonic_ranger_with_display.sv
// The result of an accepted tick item appears in the output register in the next cycle.
// Throughput: one item per cycle; a new item is taken while a result waits if
// the output register empties in the same cycle.
// The echo scale product is registered ahead from next-state values.
// Reset (rst, synchronous) clears all counters, the ranger to idle, distance to 0
// and loads the register defaults.
// ----------------------------------------------------------------------------
// ultrasonic_ranger_with_display
// Tick-driven ultrasonic ranger with an eight-digit multiplexed display.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_with_display #(
  parameter int unsigned DIGIT_COUNT = 8,
  parameter int unsigned TIMER_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,   // [0] echo_level
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] tx_level, [8:1] digit_enable, [16:9] segment_pattern,
  // [30:17] distance_cm, [31] distance_updated
  output logic [31:0]                       m_tdata,
  input  logic                              cfg_we,
  input  logic [ur_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ur_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ur_pkg::cfg_t               cfg, cfg_next;
  logic                       advance;
  logic                       trigger_pending, trigger_take;
  logic                       tx_level, distance_updated;
  logic [ur_pkg::DIST_W-1:0]  distance_next;
  ur_pkg::bcd_t [2:0]         digits_next;
  logic [7:0]                 digit_enable, segment_pattern;

  // output register handshake
  assign s_tready = ~m_tvalid | m_tready;
  assign advance  = s_tvalid & s_tready;

  ur_config u_config (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .cfg_next (cfg_next)
  );

  ur_ranger #(
    .TIMER_BITS(TIMER_BITS)
  ) u_ranger (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .echo_level      (s_tdata[0]),
    .trigger_pending (trigger_pending),
    .cfg             (cfg),
    .cfg_next        (cfg_next),
    .trigger_take    (trigger_take),
    .tx_level        (tx_level),
    .distance_updated(distance_updated),
    .distance_next   (distance_next),
    .digits_next     (digits_next)
  );

  ur_display #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_display (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .trigger_take   (trigger_take),
    .cfg            (cfg),
    .digits_next    (digits_next),
    .trigger_pending(trigger_pending),
    .digit_enable   (digit_enable),
    .segment_pattern(segment_pattern)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {distance_updated, distance_next, segment_pattern, digit_enable, tx_level};
    end
  end

endmodule
